// ----- rtl/cbpe_pkg.sv -----
// Shared types, constants and fixed-point helpers of the cubic Bezier point evaluator.
`timescale 1ns / 1ps
`default_nettype none

package cbpe_pkg;

   // Curve geometry and number formats.
   localparam int NUM_POINTS = 4;
   localparam int NUM_AXES   = 2;
   localparam int NUM_REGS   = NUM_POINTS * NUM_AXES;
   localparam int COORD_W    = 16;
   localparam int T_W        = 17;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = T_W + DIFF_W;
   localparam int FRAC_T     = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int AXIS_X     = 0;
   localparam int AXIS_Y     = 1;

   // Parameter value for t = 1.0.
   localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_T);

   // Pipeline depth from the accepting edge to the result beat.
   localparam int PIPE_STAGES = 7;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic        [T_W-1:0]     tparam_type;

   // Control point reset values, register index order.
   localparam coord_type CTRL_RESET [NUM_REGS] = '{
      -16'sd1638, 16'sd14746, -16'sd8192, 16'sd3277,
      16'sd8192, -16'sd4915, 16'sd1638, 16'sd6554
   };

   // Exact product t * (b - a).
   function automatic prod_type lerp_prod(input coord_type a, input coord_type b,
                                          input tparam_type t);
      logic signed [DIFF_W-1:0] diff;
      logic signed [T_W:0]      t_s;
      logic signed [PROD_W:0]   full;
      diff = DIFF_W'(b) - DIFF_W'(a);
      t_s  = $signed({1'b0, t});
      full = t_s * diff;
      return full[PROD_W-1:0];
   endfunction

   // a + floor(p / 2^16); the upper product bits are the floored quotient.
   function automatic coord_type lerp_sum(input coord_type a, input prod_type p);
      logic signed [PROD_W-FRAC_T-1:0] q;
      logic signed [PROD_W-FRAC_T-1:0] s;
      q = p[PROD_W-1:FRAC_T];
      s = (PROD_W-FRAC_T)'(a) + q;
      return s[COORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/cubic_bezier_point_eval_unit.sv -----
// Top level of the cubic Bezier point evaluator: de Casteljau reduction in a deep pipeline.
//
//   Channel   Ports                                   Handshake
//   -------   -------------------------------------   ---------------------------------
//   request   start, busy, req_t_param                beat taken when start && !busy
//   response  rsp_strobe, rsp_x_out, rsp_y_out        one-cycle strobe, cannot be held
//   csr       csr_write_en, csr_index, csr_data       write taken when csr_write_en
//
// One beat enters every cycle; busy stays low. Each beat passes through a parameter stage,
// then a multiply stage and an add stage for each of the three interpolation levels.
// Reset clears the valid bits and loads the control points with their defaults. The
// receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_point_eval_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [cbpe_pkg::T_W-1:0]        req_t_param,
   output logic                                 rsp_strobe,
   output logic signed [cbpe_pkg::COORD_W-1:0]  rsp_x_out,
   output logic signed [cbpe_pkg::COORD_W-1:0]  rsp_y_out,
   input  wire logic                            csr_write_en,
   input  wire logic [cbpe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [cbpe_pkg::COORD_W-1:0]    csr_data
);
   import cbpe_pkg::*;

   // Control point registers.
   coord_type  ctrl_ff [NUM_REGS];

   // Valid bits, one per stage.
   logic [PIPE_STAGES-1:0] vld_ff;
   logic [PIPE_STAGES-1:0] vld_in;

   // Stage 0: saturated parameter.
   tparam_type t0_ff;
   tparam_type t0_in;

   // Level 1: products, then sums.
   prod_type   prod1_ff [NUM_AXES][NUM_POINTS-1];
   tparam_type t1_ff;
   coord_type  sum1_ff  [NUM_AXES][NUM_POINTS-1];
   tparam_type t2_ff;

   // Level 2.
   prod_type   prod2_ff [NUM_AXES][NUM_POINTS-2];
   coord_type  base2_ff [NUM_AXES][NUM_POINTS-2];
   tparam_type t3_ff;
   coord_type  sum2_ff  [NUM_AXES][NUM_POINTS-2];
   tparam_type t4_ff;

   // Level 3.
   prod_type   prod3_ff [NUM_AXES];
   coord_type  base3_ff [NUM_AXES];
   coord_type  out_ff   [NUM_AXES];

   logic accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Configuration writes; indexes past the last register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            ctrl_ff[i] <= CTRL_RESET[i];
         end
      end else if (csr_write_en && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
         ctrl_ff[csr_index[$clog2(NUM_REGS)-1:0]] <= $signed(csr_data);
      end
   end

   // Valid bits shift one stage per cycle.
   always_comb begin
      vld_in = {vld_ff[PIPE_STAGES-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Parameters above one are clamped to one.
   always_comb begin
      t0_in = (req_t_param > T_ONE) ? T_ONE : req_t_param;
   end

   // Datapath stages; the lanes of each level run side by side.
   always_ff @(posedge clock) begin
      t0_ff <= t0_in;

      // Level 1 multiply, then add.
      t1_ff <= t0_ff;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         for (int j = 0; j < NUM_POINTS - 1; j++) begin
            prod1_ff[ax][j] <= lerp_prod(ctrl_ff[NUM_AXES*j + ax],
                                         ctrl_ff[NUM_AXES*(j+1) + ax], t0_ff);
            sum1_ff[ax][j]  <= lerp_sum(ctrl_ff[NUM_AXES*j + ax], prod1_ff[ax][j]);
         end
      end
      t2_ff <= t1_ff;

      // Level 2 multiply, then add.
      t3_ff <= t2_ff;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         for (int j = 0; j < NUM_POINTS - 2; j++) begin
            prod2_ff[ax][j] <= lerp_prod(sum1_ff[ax][j], sum1_ff[ax][j+1], t2_ff);
            base2_ff[ax][j] <= sum1_ff[ax][j];
            sum2_ff[ax][j]  <= lerp_sum(base2_ff[ax][j], prod2_ff[ax][j]);
         end
      end
      t4_ff <= t3_ff;

      // Level 3 multiply, then add into the output register.
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         prod3_ff[ax] <= lerp_prod(sum2_ff[ax][0], sum2_ff[ax][1], t4_ff);
         base3_ff[ax] <= sum2_ff[ax][0];
         out_ff[ax]   <= lerp_sum(base3_ff[ax], prod3_ff[ax]);
      end
   end

   // Result beat.
   assign rsp_strobe = vld_ff[PIPE_STAGES-1];
   assign rsp_x_out  = out_ff[AXIS_X];
   assign rsp_y_out  = out_ff[AXIS_Y];

   // A result beat always comes from a request beat taken a full pipeline earlier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, PIPE_STAGES))
      else $error("result beat without a matching request beat");

   // The clamped parameter never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> (t0_ff <= T_ONE))
      else $error("parameter escaped the clamp");

   // A zero parameter gives zero first-level products in lane 0 of both axes.
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && (t0_ff == '0)) |=>
         ((prod1_ff[AXIS_X][0] == '0) && (prod1_ff[AXIS_Y][0] == '0)))
      else $error("nonzero product for zero parameter");

endmodule

`default_nettype wire
